// ===== rtl/btc_pkg.sv =====
// Package for the box/tile-map collision unit: shared types and fixed constants.
// Depends on nothing; used by every module of the block.
package btc_pkg;

	// Tile size in pixels and fraction bits of the box coordinates.
	// TILE_PIXELS is a power of two, so floor division by a tile is an arithmetic shift.
	localparam int TILE_PIXELS = 32;
	localparam int FRAC_BITS   = 4;
	localparam int TILE_LOG2   = $clog2(TILE_PIXELS);
	localparam int SPAN_LOG2   = TILE_LOG2 + FRAC_BITS;

	// Field widths.
	localparam int BOX_XY_W  = 20;
	localparam int BOX_WH_W  = 16;
	localparam int ROW_IN_W  = 6;
	localparam int COL_IN_W  = 8;
	localparam int CODE_W    = 8;
	localparam int PX_W      = 13;
	localparam int PY_W      = 11;
	localparam int ROWS_W    = 7;
	localparam int COLS_W    = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 9;

	// Edge sums need one bit more than a coordinate; one more keeps compares safe.
	localparam int WIDE_W = BOX_XY_W + 2;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t SPAN = wide_t'(1) <<< SPAN_LOG2;

	// Request types.
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'd1;

	// One finished query result.
	typedef struct packed {
		logic            valid;
		logic            hit;
		logic [PX_W-1:0] point_x;
		logic [PY_W-1:0] point_y;
	} btc_result_t;

endpackage

// ===== rtl/btc_tile_ram.sv =====
// Tile code memory: one write port, one read port with registered read data.
// Depends on btc_pkg for the code width.
module btc_tile_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [btc_pkg::CODE_W-1:0]   wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [btc_pkg::CODE_W-1:0]   rd_data
);

	logic [btc_pkg::CODE_W-1:0] mem [DEPTH];
	logic [btc_pkg::CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/btc_scanner.sv =====
// Query sequencer: floors the box to a tile range, reads one tile per cycle
// from the tile memory and tests it. Depends on btc_pkg.
module btc_scanner #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 256,
	parameter int AW       = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  query,
	input  logic signed [btc_pkg::BOX_XY_W-1:0]   box_x,
	input  logic signed [btc_pkg::BOX_XY_W-1:0]   box_y,
	input  logic        [btc_pkg::BOX_WH_W-1:0]   box_w,
	input  logic        [btc_pkg::BOX_WH_W-1:0]   box_h,
	input  logic        [btc_pkg::ROWS_W-1:0]     map_rows,
	input  logic        [btc_pkg::COLS_W-1:0]     map_cols,
	output logic                                  rd_en,
	output logic        [AW-1:0]                  rd_addr,
	input  logic        [btc_pkg::CODE_W-1:0]     rd_data,
	output logic                                  busy,
	output btc_pkg::btc_result_t                  result
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN
	} state_t;

	state_t                state_q;
	btc_pkg::wide_t        bx_q, by_q, ex_q, ey_q;
	logic [CW-1:0]         x1_q, cx_q, cx_s1;
	logic [RW-1:0]         y0_q, y1_q, ry_q, ry_s1;
	logic                  issue_q, valid_s1, last_s1;
	btc_pkg::btc_result_t  result_q;

	// Range setup from the registered box.
	btc_pkg::wide_t x0w, x1w, y0w, y1w, x0c, x1c, y0c, y1c, rows_lim, cols_lim;
	logic           range_empty;

	always_comb begin
		x0w = bx_q >>> btc_pkg::SPAN_LOG2;
		x1w = ex_q >>> btc_pkg::SPAN_LOG2;
		y0w = by_q >>> btc_pkg::SPAN_LOG2;
		y1w = ey_q >>> btc_pkg::SPAN_LOG2;
		rows_lim = (32'(map_rows) < MAX_ROWS) ? btc_pkg::wide_t'(map_rows)
			: btc_pkg::wide_t'(MAX_ROWS);
		cols_lim = (32'(map_cols) < MAX_COLS) ? btc_pkg::wide_t'(map_cols)
			: btc_pkg::wide_t'(MAX_COLS);
		x0c = (x0w < 0) ? '0 : x0w;
		y0c = (y0w < 0) ? '0 : y0w;
		x1c = (x1w > cols_lim - 1) ? cols_lim - 1 : x1w;
		y1c = (y1w > rows_lim - 1) ? rows_lim - 1 : y1w;
		range_empty = (x0c > x1c) || (y0c > y1c);
	end

	// Scan step and memory address.
	logic last_tile;
	assign last_tile = (cx_q == x1_q) && (ry_q == y1_q);
	assign rd_en     = (state_q == ST_SCAN) && issue_q;
	assign rd_addr   = AW'(32'(ry_q) * MAX_COLS + 32'(cx_q));

	// Tile test on the data coming back from memory.
	btc_pkg::wide_t tx, ty;
	logic           solid, overlap, hit_now, scan_end;

	always_comb begin
		tx = btc_pkg::wide_t'(cx_s1) <<< btc_pkg::SPAN_LOG2;
		ty = btc_pkg::wide_t'(ry_s1) <<< btc_pkg::SPAN_LOG2;
		solid = !rd_data[btc_pkg::CODE_W-1] && (rd_data != '0);
		overlap = (bx_q < tx + btc_pkg::SPAN) && (ex_q > tx)
			&& (by_q < ty + btc_pkg::SPAN) && (ey_q > ty);
		hit_now = solid && overlap;
		scan_end = valid_s1 && (hit_now || last_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					result_q.valid <= 1'b0;
					if (query) begin
						bx_q    <= btc_pkg::wide_t'(box_x);
						by_q    <= btc_pkg::wide_t'(box_y);
						ex_q    <= btc_pkg::wide_t'(box_x) + btc_pkg::wide_t'(box_w);
						ey_q    <= btc_pkg::wide_t'(box_y) + btc_pkg::wide_t'(box_h);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (range_empty) begin
						result_q <= '{valid: 1'b1, hit: 1'b0, point_x: '0, point_y: '0};
						state_q  <= ST_IDLE;
					end else begin
						x1_q    <= CW'(x1c);
						y0_q    <= RW'(y0c);
						y1_q    <= RW'(y1c);
						cx_q    <= CW'(x0c);
						ry_q    <= RW'(y0c);
						issue_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Issue one read per cycle, column by column with rows inner.
					valid_s1 <= issue_q && !scan_end;
					if (issue_q) begin
						last_s1 <= last_tile;
						cx_s1   <= cx_q;
						ry_s1   <= ry_q;
						if (!last_tile) begin
							if (ry_q == y1_q) begin
								ry_q <= y0_q;
								cx_q <= cx_q + 1'b1;
							end else begin
								ry_q <= ry_q + 1'b1;
							end
						end
					end
					if (scan_end || last_tile) begin
						issue_q <= 1'b0;
					end
					// The first hit or the last tile ends the scan; reads in flight are dropped.
					if (scan_end) begin
						result_q.valid   <= 1'b1;
						result_q.hit     <= hit_now;
						result_q.point_x <= hit_now
							? btc_pkg::PX_W'(32'(cx_s1) << btc_pkg::TILE_LOG2) : '0;
						result_q.point_y <= hit_now
							? btc_pkg::PY_W'(32'(ry_s1) << btc_pkg::TILE_LOG2) : '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign result = result_q;

endmodule

// ===== rtl/box_tilemap_collision_unit.sv =====
// Box versus tile-map collision unit. A write item gives no result. A query item gives its
// result after the setup and scan states, and the next item may be accepted in the cycle
// of its done strobe; a query with an empty tile range skips the scan and gives a miss.
// The rate is set by the single read port of the tile memory: one tile per cycle.
// Reset (arst_n, asynchronous) clears the map size registers and the sequencer; the tile
// memory is not cleared and every tile must be written before it is queried.
module box_tilemap_collision_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item channel: accepted when start is high and busy is low.
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  req_type,
	input  logic        [btc_pkg::ROW_IN_W-1:0]   tile_row,
	input  logic        [btc_pkg::COL_IN_W-1:0]   tile_col,
	input  logic signed [btc_pkg::CODE_W-1:0]     tile_value,
	input  logic signed [btc_pkg::BOX_XY_W-1:0]   box_x,
	input  logic signed [btc_pkg::BOX_XY_W-1:0]   box_y,
	input  logic        [btc_pkg::BOX_WH_W-1:0]   box_w,
	input  logic        [btc_pkg::BOX_WH_W-1:0]   box_h,
	// Result channel: done is high for exactly one cycle per query.
	output logic                                  done,
	output logic                                  hit,
	output logic        [btc_pkg::PX_W-1:0]       point_x,
	output logic        [btc_pkg::PY_W-1:0]       point_y,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic        [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [btc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Map size registers. Values above the storage size are clamped by the sequencer.
	logic [btc_pkg::ROWS_W-1:0] map_rows_q;
	logic [btc_pkg::COLS_W-1:0] map_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= '0;
			map_cols_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				btc_pkg::REG_MAP_ROWS: map_rows_q <= cfg_wdata[btc_pkg::ROWS_W-1:0];
				btc_pkg::REG_MAP_COLS: map_cols_q <= cfg_wdata[btc_pkg::COLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item decode. A write outside the storage is dropped; a write outside the
	// configured map but inside the storage is kept.
	logic           accept, query, wr_en, in_store;
	logic [AW-1:0]  wr_addr;

	assign accept   = start && !busy;
	assign in_store = (32'(tile_row) < MAX_ROWS) && (32'(tile_col) < MAX_COLS);
	assign wr_en    = accept && (req_type == btc_pkg::REQ_WRITE) && in_store;
	assign query    = accept && (req_type == btc_pkg::REQ_QUERY);
	assign wr_addr  = AW'(32'(tile_row) * MAX_COLS + 32'(tile_col));

	// Writes land only while the sequencer is idle, so a query reads the memory only after
	// the last write it depends on has landed.
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic [btc_pkg::CODE_W-1:0]    rd_data;
	btc_pkg::btc_result_t          result;

	btc_tile_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (tile_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	btc_scanner #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (query),
		.box_x    (box_x),
		.box_y    (box_y),
		.box_w    (box_w),
		.box_h    (box_h),
		.map_rows (map_rows_q),
		.map_cols (map_cols_q),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.busy     (busy),
		.result   (result)
	);

	assign done    = result.valid;
	assign hit     = result.hit;
	assign point_x = result.point_x;
	assign point_y = result.point_y;

endmodule

// ===== tb/box_tilemap_collision_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for box_tilemap_collision_unit: fills a corner of the tile map,
// then runs directed and random box queries over several map sizes and checks every result.
// Depends on btc_pkg and on the collision unit itself.
module box_tilemap_collision_unit_test;

	// Storage geometry of the instance under test, the filled corner that queries may
	// scan, and the size of one tile in box units.
	localparam int STORE_ROWS      = 64;
	localparam int STORE_COLS      = 256;
	localparam int FILL_ROWS       = 8;
	localparam int FILL_COLS       = 32;
	localparam int TILE_UNITS      = btc_pkg::TILE_PIXELS << btc_pkg::FRAC_BITS;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int PHASES          = 10;

	// One item as offered on the input channel.
	typedef struct {
		btc_pkg::req_t                       kind;
		logic        [btc_pkg::ROW_IN_W-1:0] row;
		logic        [btc_pkg::COL_IN_W-1:0] col;
		logic signed [btc_pkg::CODE_W-1:0]   value;
		logic signed [btc_pkg::BOX_XY_W-1:0] box_x;
		logic signed [btc_pkg::BOX_XY_W-1:0] box_y;
		logic        [btc_pkg::BOX_WH_W-1:0] box_w;
		logic        [btc_pkg::BOX_WH_W-1:0] box_h;
	} tile_req_t;

	// The answer to one box query.
	typedef struct {
		logic                     hit;
		logic [btc_pkg::PX_W-1:0] px;
		logic [btc_pkg::PY_W-1:0] py;
	} contact_t;

	// Every input is known from time zero.
	logic                                clk        = 1'b0;
	logic                                arst_n     = 1'b0;
	logic                                start      = 1'b0;
	logic                                req_type   = 1'b0;
	logic        [btc_pkg::ROW_IN_W-1:0] tile_row   = '0;
	logic        [btc_pkg::COL_IN_W-1:0] tile_col   = '0;
	logic signed [btc_pkg::CODE_W-1:0]   tile_value = '0;
	logic signed [btc_pkg::BOX_XY_W-1:0] box_x      = '0;
	logic signed [btc_pkg::BOX_XY_W-1:0] box_y      = '0;
	logic        [btc_pkg::BOX_WH_W-1:0] box_w      = '0;
	logic        [btc_pkg::BOX_WH_W-1:0] box_h      = '0;
	logic                                cfg_we     = 1'b0;
	logic       [btc_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
	logic       [btc_pkg::CFG_DAT_W-1:0] cfg_wdata  = '0;
	logic                                busy;
	logic                                done;
	logic                                hit;
	logic            [btc_pkg::PX_W-1:0] point_x;
	logic            [btc_pkg::PY_W-1:0] point_y;

	// Items waiting to be driven, and query answers waiting for their done strobe.
	tile_req_t req_q[$];
	contact_t  contact_q[$];

	// Our own copy of the tile map and of the map size registers.
	logic [btc_pkg::CODE_W-1:0] tile_mem [STORE_ROWS*STORE_COLS];
	logic [btc_pkg::ROWS_W-1:0] map_rows_now = '0;
	logic [btc_pkg::COLS_W-1:0] map_cols_now = '0;

	// Map size the stimulus aims its boxes at; follows the last register writes.
	int gen_rows = 0;
	int gen_cols = 0;

	// Driver bookkeeping: acceptance seen at the last rising edge, idle cycles left
	// before the next item, and items left in a stretch with no idling at all.
	logic taken      = 1'b0;
	int   gap_left   = 0;
	int   burst_left = 0;

	int n_bad     = 0;
	int n_writes  = 0;
	int n_queries = 0;
	int n_hits    = 0;
	int n_results = 0;
	int n_maps    = 0;

	box_tilemap_collision_unit #(
		.MAX_ROWS(STORE_ROWS),
		.MAX_COLS(STORE_COLS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.tile_row  (tile_row),
		.tile_col  (tile_col),
		.tile_value(tile_value),
		.box_x     (box_x),
		.box_y     (box_y),
		.box_w     (box_w),
		.box_h     (box_h),
		.done      (done),
		.hit       (hit),
		.point_x   (point_x),
		.point_y   (point_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// The slowest legal run is set by the large boxes that scan the whole filled corner
	// and by the long idle pauses; together they stay below 10 ms, so 60 ms is ample.
	initial begin
		#60_000_000;
		$display("Timed out with %0d items still queued and %0d answers outstanding.",
			req_q.size(), contact_q.size());
		$display("box_tilemap_collision_unit: mismatch");
		$finish;
	end

	task automatic log_failure(input string msg);
		n_bad++;
		if (n_bad <= 10) begin
			$display("[%0t ns] %s", $time, msg);
		end
	endtask

	// Floor of a box coordinate divided by the tile size, exact for negative values.
	function automatic longint tile_floor(input longint v);
		if (v >= 0) begin
			return v / TILE_UNITS;
		end
		return -((-v + TILE_UNITS - 1) / TILE_UNITS);
	endfunction

	// Works out the answer to a box query against the current map: the tile range is
	// scanned column by column with rows inner, and the first solid tile that the box
	// strictly overlaps wins.
	function automatic contact_t collide_box(input tile_req_t q);
		contact_t res;
		longint   bx, by, bw, bh, c0, c1, r0, r1, nrows, ncols, cx, ry, tx, ty, corner;
		logic signed [btc_pkg::CODE_W-1:0] code;
		res.hit = 1'b0;
		res.px  = '0;
		res.py  = '0;
		bx = q.box_x;
		by = q.box_y;
		bw = longint'(q.box_w);
		bh = longint'(q.box_h);
		// Map sizes beyond the storage act as the storage size.
		nrows = (map_rows_now > STORE_ROWS) ? STORE_ROWS : longint'(map_rows_now);
		ncols = (map_cols_now > STORE_COLS) ? STORE_COLS : longint'(map_cols_now);
		c0 = tile_floor(bx);
		c1 = tile_floor(bx + bw);
		r0 = tile_floor(by);
		r1 = tile_floor(by + bh);
		if (c0 < 0) c0 = 0;
		if (r0 < 0) r0 = 0;
		if (c1 > ncols - 1) c1 = ncols - 1;
		if (r1 > nrows - 1) r1 = nrows - 1;
		for (cx = c0; cx <= c1 && !res.hit; cx++) begin
			for (ry = r0; ry <= r1 && !res.hit; ry++) begin
				code = tile_mem[ry * STORE_COLS + cx];
				tx   = cx * TILE_UNITS;
				ty   = ry * TILE_UNITS;
				if (code > 0 && bx < tx + TILE_UNITS && bx + bw > tx &&
					by < ty + TILE_UNITS && by + bh > ty) begin
					res.hit = 1'b1;
					corner  = cx * btc_pkg::TILE_PIXELS;
					res.px  = corner[btc_pkg::PX_W-1:0];
					corner  = ry * btc_pkg::TILE_PIXELS;
					res.py  = corner[btc_pkg::PY_W-1:0];
				end
			end
		end
		return res;
	endfunction

	// An item with every field random; the fields that its kind does not use stay so.
	function automatic tile_req_t noise_item();
		tile_req_t q;
		q.kind  = btc_pkg::req_t'($urandom_range(0, 1));
		q.row   = btc_pkg::ROW_IN_W'($urandom);
		q.col   = btc_pkg::COL_IN_W'($urandom);
		q.value = btc_pkg::CODE_W'($urandom);
		q.box_x = btc_pkg::BOX_XY_W'($urandom);
		q.box_y = btc_pkg::BOX_XY_W'($urandom);
		q.box_w = btc_pkg::BOX_WH_W'($urandom);
		q.box_h = btc_pkg::BOX_WH_W'($urandom);
		return q;
	endfunction

	function automatic tile_req_t tile_write(input int r, input int c, input int v);
		tile_req_t q;
		q       = noise_item();
		q.kind  = btc_pkg::REQ_WRITE;
		q.row   = btc_pkg::ROW_IN_W'(r);
		q.col   = btc_pkg::COL_IN_W'(c);
		q.value = btc_pkg::CODE_W'(v);
		return q;
	endfunction

	function automatic tile_req_t box_query(input longint x, input longint y,
		input longint w, input longint h);
		tile_req_t q;
		q       = noise_item();
		q.kind  = btc_pkg::REQ_QUERY;
		q.box_x = btc_pkg::BOX_XY_W'(x);
		q.box_y = btc_pkg::BOX_XY_W'(y);
		q.box_w = btc_pkg::BOX_WH_W'(w);
		q.box_h = btc_pkg::BOX_WH_W'(h);
		return q;
	endfunction

	// Initial tile codes. Every fourth band of 4 columns holds no solid tile, so that
	// boxes there scan their whole range and come back empty.
	function automatic int fill_code(input int c);
		int roll;
		roll = $urandom_range(0, 99);
		if (((c >> 2) % 4) == 3) begin
			return (roll < 30) ? 0 : $urandom_range(128, 255);
		end
		if (roll < 35) return $urandom_range(1, 127);
		if (roll < 50) return 0;
		return $urandom_range(128, 255);
	endfunction

	// A random query, most of them small boxes placed on and around the current map.
	// Only the filled corner of the storage may be scanned, so where the map reaches
	// past it the boxes are kept inside it.
	function automatic tile_req_t random_query();
		tile_req_t q;
		int        ecols, erows, roll;
		logic      wide_map, tall_map;
		q        = noise_item();
		q.kind   = btc_pkg::REQ_QUERY;
		ecols    = (gen_cols > STORE_COLS) ? STORE_COLS : gen_cols;
		erows    = (gen_rows > STORE_ROWS) ? STORE_ROWS : gen_rows;
		wide_map = (ecols > FILL_COLS);
		tall_map = (erows > FILL_ROWS);
		if (wide_map) ecols = FILL_COLS;
		if (tall_map) erows = FILL_ROWS;
		roll     = $urandom_range(0, 99);
		// A few queries keep fully random coordinates and sizes, the largest boxes among
		// them; that is safe only on a map that fits in the filled corner.
		if (roll >= 5 || wide_map || tall_map) begin
			q.box_x = btc_pkg::BOX_XY_W'($urandom_range(0, (ecols + 4) * TILE_UNITS)
				- 2 * TILE_UNITS);
			q.box_y = btc_pkg::BOX_XY_W'($urandom_range(0, (erows + 4) * TILE_UNITS)
				- 2 * TILE_UNITS);
			if (roll < 15) begin
				// Edges exactly on tile boundaries, where strict overlap matters.
				q.box_x[btc_pkg::SPAN_LOG2-1:0] = '0;
				q.box_y[btc_pkg::SPAN_LOG2-1:0] = '0;
				q.box_w = btc_pkg::BOX_WH_W'($urandom_range(0, 3) * TILE_UNITS);
				q.box_h = btc_pkg::BOX_WH_W'($urandom_range(0, 3) * TILE_UNITS);
			end else begin
				q.box_w = btc_pkg::BOX_WH_W'($urandom_range(0, 3 * TILE_UNITS));
				q.box_h = btc_pkg::BOX_WH_W'($urandom_range(0, 3 * TILE_UNITS));
				if (roll < 22) begin
					// Flat boxes: one side of zero length.
					if ($urandom_range(0, 1) == 1) q.box_w = '0;
					else q.box_h = '0;
				end
			end
			// Pull the far edge back into the last filled column or row.
			if (wide_map && longint'(q.box_x) + longint'(q.box_w) >= FILL_COLS * TILE_UNITS)
				q.box_x = btc_pkg::BOX_XY_W'((FILL_COLS - 1) * TILE_UNITS - int'(q.box_w));
			if (tall_map && longint'(q.box_y) + longint'(q.box_h) >= FILL_ROWS * TILE_UNITS)
				q.box_y = btc_pkg::BOX_XY_W'((FILL_ROWS - 1) * TILE_UNITS - int'(q.box_h));
		end
		return q;
	endfunction

	// Idle cycles before the next item: mostly none or a few, now and then a long pause,
	// and once in a while a stretch of back-to-back items.
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Driver. Inputs change on the falling edge. An item stays on the ports with start
	// high until a rising edge sees busy low; between items the payload ports carry
	// noise that the unit must ignore.
	always @(negedge clk) begin : drive_items
		tile_req_t nxt;
		logic      go;
		go = start && !taken;
		if (!go) begin
			if (gap_left > 0) begin
				gap_left--;
				nxt = noise_item();
			end else if (req_q.size() != 0) begin
				nxt      = req_q.pop_front();
				go       = 1'b1;
				gap_left = pick_gap();
			end else begin
				nxt = noise_item();
			end
			req_type   <= nxt.kind;
			tile_row   <= nxt.row;
			tile_col   <= nxt.col;
			tile_value <= nxt.value;
			box_x      <= nxt.box_x;
			box_y      <= nxt.box_y;
			box_w      <= nxt.box_w;
			box_h      <= nxt.box_h;
		end
		start <= go;
	end

	// Monitor. At each rising edge: a done strobe is checked against the oldest
	// outstanding answer, an accepted item updates the map or queues its answer, and a
	// register write updates the map size. A result and the next item can share an edge;
	// the result belongs to the earlier query, so it is checked first.
	always @(posedge clk) begin : watch_results
		contact_t  want;
		tile_req_t seen;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (contact_q.size() == 0) begin
					log_failure($sformatf("result with no query outstanding: hit=%0b x=%0d y=%0d",
						hit, point_x, point_y));
				end else begin
					want = contact_q.pop_front();
					if (hit !== want.hit)
						log_failure($sformatf("hit: expected %0b, got %0b", want.hit, hit));
					if (point_x !== want.px)
						log_failure($sformatf("point_x: expected %0d, got %0d", want.px, point_x));
					if (point_y !== want.py)
						log_failure($sformatf("point_y: expected %0d, got %0d", want.py, point_y));
				end
			end
			if (start && !busy) begin
				seen.kind  = btc_pkg::req_t'(req_type);
				seen.row   = tile_row;
				seen.col   = tile_col;
				seen.value = tile_value;
				seen.box_x = box_x;
				seen.box_y = box_y;
				seen.box_w = box_w;
				seen.box_h = box_h;
				if (seen.kind == btc_pkg::REQ_QUERY) begin
					want = collide_box(seen);
					contact_q.push_back(want);
					n_queries++;
					if (want.hit) n_hits++;
				end else begin
					// Row and column fields cannot exceed the storage, so every write lands.
					tile_mem[int'(seen.row) * STORE_COLS + int'(seen.col)] = seen.value;
					n_writes++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					btc_pkg::REG_MAP_ROWS: map_rows_now = cfg_wdata[btc_pkg::ROWS_W-1:0];
					btc_pkg::REG_MAP_COLS: map_cols_now = cfg_wdata[btc_pkg::COLS_W-1:0];
					default: ;
				endcase
			end
		end
		taken <= arst_n && start && !busy;
	end

	task automatic write_reg(input logic [btc_pkg::CFG_IDX_W-1:0] idx,
		input logic [btc_pkg::CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Sets the map size. The row register is narrower than the write data, so its unused
	// upper bits carry noise that must be dropped.
	task automatic set_map(input int rows, input int cols);
		write_reg(btc_pkg::REG_MAP_ROWS, {2'($urandom), btc_pkg::ROWS_W'(rows)});
		write_reg(btc_pkg::REG_MAP_COLS, btc_pkg::COLS_W'(cols));
		gen_rows = rows;
		gen_cols = cols;
		n_maps++;
	endtask

	// Waits until every queued item was taken and every answer came back. A write gives
	// no result and does not make the unit busy, so a few idle cycles more leave the unit idle.
	task automatic settle();
		while (req_q.size() != 0 || start || contact_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin : run_phases
		int rows_set [6];
		int cols_set [6];
		int p, k, r, c;

		rows_set = '{64, 127, 1, 0, 64, 9};
		cols_set = '{256, 511, 1, 256, 0, 40};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Write every tile of the filled corner once; no query scans past it, apart from
		// single tiles that are written on purpose.
		set_map(FILL_ROWS, FILL_COLS);
		for (r = 0; r < FILL_ROWS; r++) begin
			for (c = 0; c < FILL_COLS; c++) begin
				req_q.push_back(tile_write(r, c, fill_code(c)));
			end
		end
		settle();

		// Directed part: code extremes, strict overlap at tile edges, flat boxes,
		// the far corner of the storage and boxes at the extremes of the coordinate range.
		req_q.push_back(tile_write(2, 3, 1));
		req_q.push_back(tile_write(2, 4, -128));
		req_q.push_back(tile_write(1, 3, 0));
		req_q.push_back(tile_write(63, 255, 127));
		req_q.push_back(tile_write(0, 0, 1));
		req_q.push_back(box_query(3 * TILE_UNITS + 16, 2 * TILE_UNITS + 16, 32, 32));
		req_q.push_back(box_query(3 * TILE_UNITS + 100, 2 * TILE_UNITS + 8, 0, 100));
		req_q.push_back(box_query(3 * TILE_UNITS, 2 * TILE_UNITS + 8, 0, 100));
		req_q.push_back(box_query(3 * TILE_UNITS, 2 * TILE_UNITS, TILE_UNITS, TILE_UNITS));
		req_q.push_back(box_query(3 * TILE_UNITS + 10, TILE_UNITS + 10, 20, 600));
		req_q.push_back(box_query(255 * TILE_UNITS + 1, 63 * TILE_UNITS + 1, 10, 10));
		req_q.push_back(box_query(-524288, -524288, 65535, 65535));
		req_q.push_back(box_query(524287, 524287, 65535, 65535));
		req_q.push_back(box_query(-100, -100, 65535, 65535));
		req_q.push_back(box_query(-16, -16, 20, 20));
		req_q.push_back(box_query(-16, -16, 16, 16));
		req_q.push_back(box_query(0, 0, 0, 0));
		req_q.push_back(box_query(5, 5, 0, 0));
		settle();

		// A tiny map: the solid tile at row 2 now lies outside and must be skipped.
		set_map(2, 3);
		req_q.push_back(box_query(3 * TILE_UNITS + 16, 2 * TILE_UNITS + 16, 32, 32));
		req_q.push_back(box_query(16, 16, 32, 32));
		req_q.push_back(box_query(-100, -100, 65535, 65535));
		settle();

		// Both registers at their largest codes act as the full storage.
		set_map(127, 511);
		req_q.push_back(box_query(255 * TILE_UNITS + 1, 63 * TILE_UNITS + 1, 10, 10));
		settle();

		// An empty map never hits.
		set_map(0, 0);
		req_q.push_back(box_query(16, 16, 32, 32));
		settle();

		// Random part: fixed corner settings first, then random ones; about a quarter of
		// the items rewrite tiles anywhere in storage, the rest query boxes.
		for (p = 0; p < PHASES; p++) begin
			if (p < 6) set_map(rows_set[p], cols_set[p]);
			else set_map($urandom_range(0, 127), $urandom_range(0, 511));
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					req_q.push_back(tile_write($urandom_range(0, STORE_ROWS - 1),
						$urandom_range(0, STORE_COLS - 1), $urandom_range(0, 255)));
				end else begin
					req_q.push_back(random_query());
				end
			end
			settle();
		end

		repeat (12) @(posedge clk);
		if (contact_q.size() != 0) begin
			log_failure($sformatf("%0d query answers never arrived", contact_q.size()));
		end
		$display("Covered %0d tile writes and %0d box queries (%0d expected hits) under %0d map sizes.",
			n_writes, n_queries, n_hits, n_maps);
		$display("Saw %0d results; %0d mismatches.", n_results, n_bad);
		if (n_bad == 0) begin
			$display("box_tilemap_collision_unit: match");
		end else begin
			$display("box_tilemap_collision_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/btc_pkg.sv
rtl/btc_tile_ram.sv
rtl/btc_scanner.sv
rtl/box_tilemap_collision_unit.sv
tb/box_tilemap_collision_unit_test.sv
